[rtl/core/tle_pkg.sv]
// Shared types and constants for the terminal line editor.
package tle_pkg;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // operation kinds handed from front to back
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_BS   = 2'd2;

  // register map
  localparam logic REG_MAX_LINE_CHARS = 1'b0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int TDATA_W = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] idx;
    logic [7:0] ch;
  } op_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;
  } res_t;

endpackage

[rtl/core/tle_front.sv]
// Front end: classifies received bytes, tracks count and CR flag, emits ops.
module tle_front
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] limit,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       q_full,
  output logic       push,
  output op_t        push_op
);

  logic [7:0] char_count;
  logic [7:0] char_count_next;
  logic       last_was_cr;
  logic       last_was_cr_next;
  logic       acc;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    char_count_next  = char_count;
    last_was_cr_next = last_was_cr;
    push             = 1'b0;
    push_op.kind     = OP_CHAR;
    push_op.idx      = char_count;
    push_op.ch       = s_tdata;
    if (acc) begin
      if (s_tdata == CH_BS) begin
        if (char_count != 8'd0) begin
          push            = 1'b1;
          push_op.kind    = OP_BS;
          char_count_next = char_count - 8'd1;
        end
      end else if (s_tdata == CH_LF && last_was_cr) begin
        last_was_cr_next = 1'b0;
      end else if (s_tdata == CH_CR || s_tdata == CH_LF || s_tdata == CH_ESC) begin
        push            = 1'b1;
        push_op.kind    = OP_EOL;
        char_count_next = 8'd0;
        if (s_tdata == CH_CR) begin
          last_was_cr_next = 1'b1;
        end
      end else if (char_count < limit) begin
        push            = 1'b1;
        char_count_next = char_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= 8'd0;
      last_was_cr <= 1'b0;
    end else begin
      char_count  <= char_count_next;
      last_was_cr <= last_was_cr_next;
    end
  end

endmodule

[rtl/core/tle_queue.sv]
// Small op queue between front and back.
module tle_queue
  import tle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic empty,
  output logic full,
  output op_t  head
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   cnt;

  assign empty = (cnt == '0);
  assign full  = (cnt == (QPTR_W+1)'(QDEPTH));
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      cnt <= cnt + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

[rtl/core/tle_back.sv]
// Back end: expands queued ops into result words behind an output register.
module tle_back
  import tle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  op_t  head,
  output logic pop,
  output logic m_tvalid,
  input  logic m_tready,
  output res_t res
);

  logic [1:0] phase;
  logic       load;
  logic       final_word;
  res_t       res_next;

  assign load       = !q_empty && (!m_tvalid || m_tready);
  assign final_word = (head.kind != OP_BS) || (phase == 2'd2);
  assign pop        = load && final_word;

  always_comb begin
    res_next             = '0;
    res_next.tx_valid    = 1'b1;
    res_next.last        = final_word;
    case (head.kind)
      OP_BS: begin
        res_next.tx_byte = (phase == 2'd1) ? CH_SP : CH_BS;
      end
      OP_EOL: begin
        res_next.tx_byte     = CH_LF;
        res_next.store_valid = 1'b1;
        res_next.store_index = head.idx;
        res_next.line_done   = 1'b1;
        res_next.line_length = head.idx;
      end
      default: begin
        res_next.tx_byte     = head.ch;
        res_next.store_valid = 1'b1;
        res_next.store_index = head.idx;
        res_next.store_char  = head.ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= final_word ? 2'd0 : phase + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/terminal_line_editor.sv]
// Path: an accepted byte is written into the op queue, and its result word is
//   then loaded into the output register; the load waits while the output stalls.
// Throughput: one byte per cycle while the queue is not full; a backspace expands
//   into three output words, one word per cycle while the output is not stalled.
// Reset (rst, synchronous): count and CR flag cleared, queue emptied,
//   output invalid, max_line_chars back to 255.
// Top level: console line editing with echo, store and end-of-line report.
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // received bytes
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_char
  // result words
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] store_valid, [17:10] store_index,
  // [25:18] store_char, [26] line_done, [34:27] line_length, rest zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  // storable characters are capped by the buffer (one byte kept for the
  // terminator) and by the 8-bit count
  localparam logic [7:0] CAP =
    8'((LINE_BUFFER_BYTES - 1 > 255) ? 255 : LINE_BUFFER_BYTES - 1);

  logic [7:0] max_line_chars;
  logic [7:0] limit;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  op_t        push_op;
  op_t        head;
  res_t       res;

  // config register; only the word-select bit of the address is decoded
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LINE_CHARS) ? {24'd0, max_line_chars} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_chars <= 8'd255;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_MAX_LINE_CHARS) begin
      max_line_chars <= pwdata[7:0];
    end
  end

  assign limit = (max_line_chars < CAP) ? max_line_chars : CAP;

  // front: classify bytes and update line state at accept time
  tle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .limit    (limit),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  // decouples byte intake from multi-word echo output
  tle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .empty   (q_empty),
    .full    (q_full),
    .head    (head)
  );

  // back: one word per cycle into the output register while the output is not stalled
  tle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {5'd0, res.line_length, res.line_done, res.store_char,
                    res.store_index, res.store_valid, res.tx_byte, res.tx_valid};
  assign m_tlast = res.last;

endmodule
